// ===== rtl/plc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    // Default sizes of the window and the datapath
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int DWELL_BITS_DEF   = 10;

    // Configuration port layout
    localparam int CFG_BITS       = 12;
    localparam int MIN_DWELL_BITS = 10;
    localparam int CFG_INDEX_BITS = 3;

    // Window contents after reset
    localparam int FILL_LEVEL = 3000;

    // Register reset values
    localparam int ACCEPT_THR_RST   = 1400;
    localparam int READY_LOW_RST    = 1600;
    localparam int READY_HIGH_RST   = 2000;
    localparam int PRESENT_LOW_RST  = 2100;
    localparam int PRESENT_HIGH_RST = 2250;
    localparam int ABSENT_LOW_RST   = 2350;
    localparam int MIN_DWELL_RST    = 55;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ACCEPT_THR   = 3'd0,
        CFG_READY_LOW    = 3'd1,
        CFG_READY_HIGH   = 3'd2,
        CFG_PRESENT_LOW  = 3'd3,
        CFG_PRESENT_HIGH = 3'd4,
        CFG_ABSENT_LOW   = 3'd5,
        CFG_MIN_DWELL    = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        CLS_ABSENT  = 2'd0,
        CLS_PRESENT = 2'd1,
        CLS_READY   = 2'd2
    } t_class;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_DELETE   = 3'd1,
        SEQ_INSERT   = 3'd2,
        SEQ_MULT     = 3'd3,
        SEQ_FIX      = 3'd4,
        SEQ_CLASSIFY = 3'd5
    } t_seq;

    // Per-cycle command to every cell of the sorted chain
    typedef struct packed {
        logic del;
        logic ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/plc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int                     SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int                     AGE_BITS    = 4,
    parameter int                     AGE_OLD     = 15,
    parameter int                     AGE_INIT    = 0,
    parameter bit                     IS_TOP      = 1'b0,
    parameter logic [SAMPLE_BITS-1:0] INIT_VAL    = '0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_dn_val,
    input  wire logic [AGE_BITS-1:0]    i_dn_age,
    input  wire logic                   i_dn_gt,
    input  wire logic                   i_dn_hit,
    input  wire logic [SAMPLE_BITS-1:0] i_dn_rm,
    input  wire logic [SAMPLE_BITS-1:0] i_up_val,
    input  wire logic [AGE_BITS-1:0]    i_up_age,
    output logic      [SAMPLE_BITS-1:0] o_val,
    output logic      [AGE_BITS-1:0]    o_age,
    output logic                        o_gt,
    output logic                        o_hit,
    output logic      [SAMPLE_BITS-1:0] o_rm
);

    logic [SAMPLE_BITS-1:0] r_val, n_val;
    logic [AGE_BITS-1:0]    r_age, n_age;
    logic                   w_old;

    // Oldest entry of the window lives here
    assign w_old = (r_age == AGE_BITS'(AGE_OLD));

    // Ripple the removal point and removed value upward
    assign o_hit = i_dn_hit | w_old;
    assign o_rm  = w_old ? r_val : i_dn_rm;

    // The top cell is the free slot during insert, so it counts as larger
    assign o_gt  = IS_TOP ? 1'b1 : (r_val > i_sample);

    assign o_val = r_val;
    assign o_age = r_age;

    // Delete: close the gap from above and age everyone; insert: open a gap
    always_comb begin
        n_val = r_val;
        n_age = r_age;
        if (i_ctl.del) begin
            if (o_hit) begin
                n_val = i_up_val;
                n_age = i_up_age + AGE_BITS'(1);
            end else begin
                n_age = r_age + AGE_BITS'(1);
            end
        end else if (i_ctl.ins) begin
            if (i_dn_gt) begin
                n_val = i_dn_val;
                n_age = i_dn_age;
            end else if (o_gt) begin
                n_val = i_sample;
                n_age = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= INIT_VAL;
            r_age <= AGE_BITS'(AGE_INIT);
        end else begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pilot_level_classifier_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_ready   i_pilot_mv
// out       source     o_out_valid / i_out_ready o_vehicle_state, o_filtered_mv, o_state_changed
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample above the threshold runs through these steps before the next possible
// transfer: delete oldest, insert new in the sorted cell chain, reciprocal
// multiply, quotient correction, classify. A rejected sample goes straight to classify.
// Reset is synchronous; the window comes out of reset full, no clearing pass.
// The result sits in an output register; while it is not taken, the next item
// is still accepted and runs up to its classify step, where it waits.

module pilot_level_classifier_unit
    import plc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int DWELL_BITS   = DWELL_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]    i_pilot_mv,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [1:0]                o_vehicle_state,
    output logic      [SAMPLE_BITS-1:0]    o_filtered_mv,
    output logic                           o_state_changed,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]       i_cfg_data
);

    localparam int AGE_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int HALF        = WINDOW_DEPTH / 2;
    localparam int UPPER_COUNT = WINDOW_DEPTH - HALF;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(UPPER_COUNT + 1);
    localparam int MUL_BITS    = SUM_BITS + 1;
    localparam int PROD_BITS   = SUM_BITS + MUL_BITS;
    localparam int CMP_BITS    = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int DCMP_BITS   = (DWELL_BITS > MIN_DWELL_BITS) ? DWELL_BITS : MIN_DWELL_BITS;

    localparam logic [MUL_BITS-1:0]    RECIP     = MUL_BITS'((64'd1 << SUM_BITS) / UPPER_COUNT);
    localparam logic [SAMPLE_BITS-1:0] FILL_VAL  = SAMPLE_BITS'(FILL_LEVEL);
    localparam logic [SUM_BITS-1:0]    SUM_INIT  = SUM_BITS'(UPPER_COUNT * int'(FILL_VAL));
    localparam logic [SUM_BITS-1:0]    UPPER_W   = SUM_BITS'(UPPER_COUNT);
    localparam logic [DWELL_BITS-1:0]  DWELL_MAX = {DWELL_BITS{1'b1}};

    // Sequencer
    t_seq      r_state, n_state;
    t_cell_ctl w_ctl;
    logic      w_in_fire;
    logic      w_accept;
    logic      w_load_out;

    // Configuration
    logic [CFG_BITS-1:0]       r_accept_thr, r_ready_low, r_ready_high;
    logic [CFG_BITS-1:0]       r_present_low, r_present_high, r_absent_low;
    logic [MIN_DWELL_BITS-1:0] r_min_dwell;

    // Datapath
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SUM_BITS-1:0]    r_sum;
    logic [PROD_BITS-1:0]   r_prod;
    logic [SAMPLE_BITS-1:0] r_held;
    logic [SUM_BITS-1:0]    w_q0, w_rem, w_q;
    logic [SAMPLE_BITS-1:0] w_sub, w_add;

    // Classifier
    t_class                 r_class, w_next_class;
    logic [DWELL_BITS-1:0]  r_dwell, w_dwell_inc;
    logic                   r_first;
    logic                   w_may, w_changed;
    logic [CMP_BITS-1:0]    w_level;

    // Output register
    logic                   r_out_valid;
    t_class                 r_out_state;
    logic [SAMPLE_BITS-1:0] r_out_level;
    logic                   r_out_changed;

    // Chain wiring
    logic [SAMPLE_BITS-1:0] w_val    [WINDOW_DEPTH];
    logic [AGE_BITS-1:0]    w_age    [WINDOW_DEPTH];
    logic                   w_gt     [WINDOW_DEPTH];
    logic                   w_hit    [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] w_rm     [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] w_dn_val [WINDOW_DEPTH];
    logic [AGE_BITS-1:0]    w_dn_age [WINDOW_DEPTH];
    logic                   w_dn_gt  [WINDOW_DEPTH];
    logic                   w_dn_hit [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] w_dn_rm  [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] w_up_val [WINDOW_DEPTH];
    logic [AGE_BITS-1:0]    w_up_age [WINDOW_DEPTH];
    logic                   w_sorted;

    // Handshakes
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign w_accept    = CMP_BITS'(i_pilot_mv) > CMP_BITS'(r_accept_thr);
    assign o_cfg_ready = 1'b1;

    // Next state and chain commands
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = w_accept ? SEQ_DELETE : SEQ_CLASSIFY;
                end
            end
            SEQ_DELETE: begin
                w_ctl.del = 1'b1;
                n_state   = SEQ_INSERT;
            end
            SEQ_INSERT: begin
                w_ctl.ins = 1'b1;
                n_state   = SEQ_MULT;
            end
            SEQ_MULT: begin
                n_state = SEQ_FIX;
            end
            SEQ_FIX: begin
                n_state = SEQ_CLASSIFY;
            end
            SEQ_CLASSIFY: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_thr   <= CFG_BITS'(ACCEPT_THR_RST);
            r_ready_low    <= CFG_BITS'(READY_LOW_RST);
            r_ready_high   <= CFG_BITS'(READY_HIGH_RST);
            r_present_low  <= CFG_BITS'(PRESENT_LOW_RST);
            r_present_high <= CFG_BITS'(PRESENT_HIGH_RST);
            r_absent_low   <= CFG_BITS'(ABSENT_LOW_RST);
            r_min_dwell    <= MIN_DWELL_BITS'(MIN_DWELL_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ACCEPT_THR:   r_accept_thr   <= i_cfg_data;
                CFG_READY_LOW:    r_ready_low    <= i_cfg_data;
                CFG_READY_HIGH:   r_ready_high   <= i_cfg_data;
                CFG_PRESENT_LOW:  r_present_low  <= i_cfg_data;
                CFG_PRESENT_HIGH: r_present_high <= i_cfg_data;
                CFG_ABSENT_LOW:   r_absent_low   <= i_cfg_data;
                CFG_MIN_DWELL:    r_min_dwell    <= i_cfg_data[MIN_DWELL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Hold the sample for the chain
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample <= i_pilot_mv;
        end
    end

    // Sorted chain of cells, ascending from cell 0
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_bottom
            assign w_dn_val[g] = '0;
            assign w_dn_age[g] = '0;
            assign w_dn_gt[g]  = 1'b0;
            assign w_dn_hit[g] = 1'b0;
            assign w_dn_rm[g]  = '0;
        end else begin : g_link_dn
            assign w_dn_val[g] = w_val[g-1];
            assign w_dn_age[g] = w_age[g-1];
            assign w_dn_gt[g]  = w_gt[g-1];
            assign w_dn_hit[g] = w_hit[g-1];
            assign w_dn_rm[g]  = w_rm[g-1];
        end
        if (g == WINDOW_DEPTH - 1) begin : g_top
            assign w_up_val[g] = w_val[g];
            assign w_up_age[g] = w_age[g];
        end else begin : g_link_up
            assign w_up_val[g] = w_val[g+1];
            assign w_up_age[g] = w_age[g+1];
        end

        plc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_BITS    (AGE_BITS),
            .AGE_OLD     (WINDOW_DEPTH - 1),
            .AGE_INIT    (g),
            .IS_TOP      (g == WINDOW_DEPTH - 1),
            .INIT_VAL    (FILL_VAL)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (r_sample),
            .i_dn_val (w_dn_val[g]),
            .i_dn_age (w_dn_age[g]),
            .i_dn_gt  (w_dn_gt[g]),
            .i_dn_hit (w_dn_hit[g]),
            .i_dn_rm  (w_dn_rm[g]),
            .i_up_val (w_up_val[g]),
            .i_up_age (w_up_age[g]),
            .o_val    (w_val[g]),
            .o_age    (w_age[g]),
            .o_gt     (w_gt[g]),
            .o_hit    (w_hit[g]),
            .o_rm     (w_rm[g])
        );
    end

    // Upper-half sum: the entry leaving the upper half on delete, entering on insert
    assign w_sub = w_hit[HALF-1] ? w_val[HALF] : w_rm[WINDOW_DEPTH-1];
    assign w_add = w_gt[HALF-1] ? w_val[HALF-1] : r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_INIT;
        end else if (w_ctl.del) begin
            r_sum <= r_sum - SUM_BITS'(w_sub);
        end else if (w_ctl.ins) begin
            r_sum <= r_sum + SUM_BITS'(w_add);
        end
    end

    // Divide by the half size: reciprocal multiply, then one correction step
    assign w_q0  = r_prod[SUM_BITS +: SUM_BITS];
    assign w_rem = r_sum - SUM_BITS'(w_q0 * UPPER_W);
    assign w_q   = (w_rem >= UPPER_W) ? (w_q0 + SUM_BITS'(1)) : w_q0;

    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_MULT) begin
            r_prod <= PROD_BITS'(r_sum) * PROD_BITS'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_state == SEQ_FIX) begin
            r_held <= w_q[SAMPLE_BITS-1:0];
        end
    end

    // Band decision gated by dwell
    assign w_level     = CMP_BITS'(r_held);
    assign w_dwell_inc = (r_dwell == DWELL_MAX) ? r_dwell : (r_dwell + DWELL_BITS'(1));
    assign w_may       = DCMP_BITS'(w_dwell_inc) > DCMP_BITS'(r_min_dwell);

    always_comb begin
        w_next_class = r_class;
        if (w_may && (w_level > CMP_BITS'(r_ready_low))
                  && (w_level < CMP_BITS'(r_ready_high))) begin
            w_next_class = CLS_READY;
        end else if (w_may && (w_level >= CMP_BITS'(r_present_low))
                           && (w_level < CMP_BITS'(r_present_high))) begin
            w_next_class = CLS_PRESENT;
        end else if (w_may && (w_level >= CMP_BITS'(r_absent_low))) begin
            w_next_class = CLS_ABSENT;
        end
    end

    assign w_changed = r_first || (w_next_class != r_class);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= CLS_ABSENT;
            r_dwell <= '0;
            r_first <= 1'b1;
        end else if (w_load_out) begin
            r_class <= w_next_class;
            r_dwell <= w_changed ? '0 : w_dwell_inc;
            r_first <= 1'b0;
        end
    end

    // Output register: load on classify, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_state   <= w_next_class;
            r_out_level   <= r_held;
            r_out_changed <= w_changed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_vehicle_state = r_out_state;
    assign o_filtered_mv   = r_out_level;
    assign o_state_changed = r_out_changed;

    // Chain order check
    always_comb begin
        w_sorted = 1'b1;
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            if (w_val[i] > w_val[i+1]) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_oldest_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_DELETE) |-> w_hit[WINDOW_DEPTH-1])
        else $error("no oldest entry in the chain at delete");

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_IDLE) |-> w_sorted)
        else $error("cell chain out of order");

    a_quot_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_FIX) |-> ((w_rem < UPPER_W) || ((w_rem - UPPER_W) < UPPER_W)))
        else $error("reciprocal estimate off by more than one");

    a_dwell_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_state_changed) |-> (r_dwell != '0))
        else $error("dwell cleared without a state change");

endmodule

`default_nettype wire

// ===== verif/pilot_level_classifier_unit_tb.sv =====
`timescale 1ns / 1ps

module pilot_level_classifier_unit_tb;
    import plc_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int CLK_PERIOD      = 2 * CLK_HALF;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 13;
    localparam int PHASE_ITEMS     = 64;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int NUM_CLASSES     = 3;
    localparam int MAX_MV          = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int DWELL_TOP       = (1 << DWELL_BITS_DEF) - 1;
    localparam int UPPER_COUNT     = WINDOW_DEPTH_DEF - WINDOW_DEPTH_DEF / 2;
    localparam int MAX_MIN_DWELL   = (1 << MIN_DWELL_BITS) - 1;

    // Index past the last register; writes to it must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        t_class                     state;
        logic [SAMPLE_BITS_DEF-1:0] level;
        logic                       changed;
    } t_pilot_reading;

    typedef struct packed {
        logic [CFG_BITS-1:0] accept_thr;
        logic [CFG_BITS-1:0] ready_lo;
        logic [CFG_BITS-1:0] ready_hi;
        logic [CFG_BITS-1:0] present_lo;
        logic [CFG_BITS-1:0] present_hi;
        logic [CFG_BITS-1:0] absent_lo;
        logic [CFG_BITS-1:0] min_dwell;
    } t_band_setup;

    // Mirror of the classifier: window, level, class and dwell, plus readings in flight
    class pilot_scoreboard;
        logic [CFG_BITS-1:0]        accept_thr;
        logic [CFG_BITS-1:0]        ready_lo;
        logic [CFG_BITS-1:0]        ready_hi;
        logic [CFG_BITS-1:0]        present_lo;
        logic [CFG_BITS-1:0]        present_hi;
        logic [CFG_BITS-1:0]        absent_lo;
        logic [MIN_DWELL_BITS-1:0]  min_dwell;
        logic [SAMPLE_BITS_DEF-1:0] window_mv [WINDOW_DEPTH_DEF];
        int unsigned                oldest;
        logic [SAMPLE_BITS_DEF-1:0] level;
        t_class                     cls;
        int unsigned                dwell;
        bit                         first_item;
        t_pilot_reading             awaited_readings [$];
        int unsigned                errors;
        int unsigned                samples;
        int unsigned                readings;
        int unsigned                changes;
        int unsigned                class_hits [NUM_CLASSES];

        function new();
            accept_thr = CFG_BITS'(ACCEPT_THR_RST);
            ready_lo   = CFG_BITS'(READY_LOW_RST);
            ready_hi   = CFG_BITS'(READY_HIGH_RST);
            present_lo = CFG_BITS'(PRESENT_LOW_RST);
            present_hi = CFG_BITS'(PRESENT_HIGH_RST);
            absent_lo  = CFG_BITS'(ABSENT_LOW_RST);
            min_dwell  = MIN_DWELL_BITS'(MIN_DWELL_RST);
            foreach (window_mv[i]) window_mv[i] = SAMPLE_BITS_DEF'(FILL_LEVEL);
            oldest     = 0;
            level      = '0;
            cls        = CLS_ABSENT;
            dwell      = 0;
            first_item = 1'b1;
            errors     = 0;
            samples    = 0;
            readings   = 0;
            changes    = 0;
            foreach (class_hits[i]) class_hits[i] = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                CFG_ACCEPT_THR:   accept_thr = data;
                CFG_READY_LOW:    ready_lo = data;
                CFG_READY_HIGH:   ready_hi = data;
                CFG_PRESENT_LOW:  present_lo = data;
                CFG_PRESENT_HIGH: present_hi = data;
                CFG_ABSENT_LOW:   absent_lo = data;
                CFG_MIN_DWELL:    min_dwell = data[MIN_DWELL_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Mean of the upper half of the window, rounded down
        function logic [SAMPLE_BITS_DEF-1:0] upper_mean();
            int sorted_mv [$];
            int sum;
            sum = 0;
            foreach (window_mv[i]) sorted_mv.push_back(int'(window_mv[i]));
            sorted_mv.sort();
            for (int i = WINDOW_DEPTH_DEF / 2; i < WINDOW_DEPTH_DEF; i++) begin
                sum += sorted_mv[i];
            end
            return SAMPLE_BITS_DEF'(sum / UPPER_COUNT);
        endfunction

        // Advance the mirror by one transferred sample and queue the reading it yields
        function void note_sample(logic [SAMPLE_BITS_DEF-1:0] mv);
            t_pilot_reading r;
            t_class         next_cls;
            bit             may_change;
            samples++;
            if (dwell < DWELL_TOP) dwell++;
            if (mv > accept_thr) begin
                window_mv[oldest] = mv;
                oldest = (oldest + 1) % WINDOW_DEPTH_DEF;
                level = upper_mean();
            end
            next_cls = cls;
            may_change = dwell > min_dwell;
            if (may_change && level > ready_lo && level < ready_hi) begin
                next_cls = CLS_READY;
            end else if (may_change && level >= present_lo && level < present_hi) begin
                next_cls = CLS_PRESENT;
            end else if (may_change && level >= absent_lo) begin
                next_cls = CLS_ABSENT;
            end
            r.changed = first_item || (next_cls != cls);
            if (r.changed) dwell = 0;
            cls = next_cls;
            first_item = 1'b0;
            r.state = cls;
            r.level = level;
            awaited_readings.push_back(r);
        endfunction

        function int pending();
            return awaited_readings.size();
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one transferred reading with the oldest one awaited
        task check_reading(logic [1:0] st, logic [SAMPLE_BITS_DEF-1:0] mv, logic ch);
            t_pilot_reading want;
            if (awaited_readings.size() == 0) begin
                report($sformatf("reading with none awaited: state %0d level %0d changed %0b",
                                 st, mv, ch));
                return;
            end
            want = awaited_readings.pop_front();
            readings++;
            if (ch === 1'b1) changes++;
            if (st < NUM_CLASSES) class_hits[st]++;
            if (st !== want.state) begin
                report($sformatf("reading %0d: vehicle_state %0d, want %0d",
                                 readings, st, want.state));
            end
            if (mv !== want.level) begin
                report($sformatf("reading %0d: filtered_mv %0d, want %0d",
                                 readings, mv, want.level));
            end
            if (ch !== want.changed) begin
                report($sformatf("reading %0d: state_changed %0b, want %0b",
                                 readings, ch, want.changed));
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [SAMPLE_BITS_DEF-1:0] i_pilot_mv = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [1:0]                 o_vehicle_state;
    logic [SAMPLE_BITS_DEF-1:0] o_filtered_mv;
    logic                       o_state_changed;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_BITS-1:0]        i_cfg_data = '0;

    pilot_scoreboard sb;
    bit              src_gaps = 1'b1;
    bit              sink_gaps = 1'b1;
    bit              hold_off_req = 1'b0;
    int              hold_offs = 0;
    int              setups_applied = 0;

    pilot_level_classifier_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pilot_mv     (i_pilot_mv),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vehicle_state(o_vehicle_state),
        .o_filtered_mv  (o_filtered_mv),
        .o_state_changed(o_state_changed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [SAMPLE_BITS_DEF-1:0] clip_mv(input int mv);
        if (mv < 0) return '0;
        if (mv > MAX_MV) return SAMPLE_BITS_DEF'(MAX_MV);
        return mv[SAMPLE_BITS_DEF-1:0];
    endfunction

    // Offer one sample; return at the falling edge after its transfer, valid still high
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] mv);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pilot_mv <= mv;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_sample(mv);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every reading is back and the block has settled
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Reprogram every register while idle; the unused index must have no effect
    task automatic apply_setup(input t_band_setup s);
        wait_drained();
        write_reg(CFG_UNUSED, CFG_BITS'($urandom_range(0, MAX_MV)));
        write_reg(CFG_ACCEPT_THR, s.accept_thr);
        write_reg(CFG_READY_LOW, s.ready_lo);
        write_reg(CFG_READY_HIGH, s.ready_hi);
        write_reg(CFG_PRESENT_LOW, s.present_lo);
        write_reg(CFG_PRESENT_HIGH, s.present_hi);
        write_reg(CFG_ABSENT_LOW, s.absent_lo);
        write_reg(CFG_MIN_DWELL, s.min_dwell);
        i_cfg_valid <= 1'b0;
        setups_applied++;
    endtask

    // Accept everything above zero; each band either gets the widest bounds or is empty
    function automatic t_band_setup open_bands(input bit ready_on, input bit present_on,
                                               input bit absent_on, input int dwell_min);
        t_band_setup s;
        s.accept_thr = '0;
        s.ready_lo   = ready_on ? '0 : CFG_BITS'(MAX_MV);
        s.ready_hi   = ready_on ? CFG_BITS'(MAX_MV) : '0;
        s.present_lo = present_on ? '0 : CFG_BITS'(MAX_MV);
        s.present_hi = present_on ? CFG_BITS'(MAX_MV) : '0;
        s.absent_lo  = absent_on ? '0 : CFG_BITS'(MAX_MV);
        s.min_dwell  = CFG_BITS'(dwell_min);
        return s;
    endfunction

    // Bands stacked in order with random widths and gaps
    function automatic t_band_setup graded_setup();
        t_band_setup s;
        int mark;
        mark = $urandom_range(200, 1400);
        s.ready_lo = clip_mv(mark);
        s.accept_thr = clip_mv($urandom_range(0, mark));
        mark += $urandom_range(80, 600);
        s.ready_hi = clip_mv(mark);
        mark += $urandom_range(0, 200);
        s.present_lo = clip_mv(mark);
        mark += $urandom_range(80, 600);
        s.present_hi = clip_mv(mark);
        mark += $urandom_range(0, 200);
        s.absent_lo = clip_mv(mark);
        s.min_dwell = CFG_BITS'($urandom_range(0, 24) + ($urandom_range(0, 3) << MIN_DWELL_BITS));
        return s;
    endfunction

    // Bounds anywhere, so bands overlap or invert
    function automatic t_band_setup scrambled_setup();
        t_band_setup s;
        s.accept_thr = clip_mv($urandom_range(0, 2000));
        s.ready_lo   = clip_mv($urandom_range(0, MAX_MV));
        s.ready_hi   = clip_mv($urandom_range(0, MAX_MV));
        s.present_lo = clip_mv($urandom_range(0, MAX_MV));
        s.present_hi = clip_mv($urandom_range(0, MAX_MV));
        s.absent_lo  = clip_mv($urandom_range(0, MAX_MV));
        s.min_dwell  = CFG_BITS'($urandom_range(0, 40) + ($urandom_range(0, 3) << MIN_DWELL_BITS));
        return s;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return CFG_BITS'(MAX_MV);
            default: return CFG_BITS'($urandom_range(0, MAX_MV));
        endcase
    endfunction

    function automatic t_band_setup extreme_setup();
        t_band_setup s;
        s.accept_thr = pick_extreme();
        s.ready_lo   = pick_extreme();
        s.ready_hi   = pick_extreme();
        s.present_lo = pick_extreme();
        s.present_hi = pick_extreme();
        s.absent_lo  = pick_extreme();
        case ($urandom_range(0, 3))
            0: s.min_dwell = '0;
            1: s.min_dwell = CFG_BITS'(MAX_MIN_DWELL - 1);
            2: s.min_dwell = CFG_BITS'(MAX_MIN_DWELL);
            default: s.min_dwell = CFG_BITS'($urandom_range(0, 12));
        endcase
        s.min_dwell[CFG_BITS-1:MIN_DWELL_BITS] =
            (CFG_BITS - MIN_DWELL_BITS)'($urandom_range(0, 3));
        return s;
    endfunction

    // Aim a run of samples at one of the bands or anywhere
    function automatic int pick_target();
        case ($urandom_range(0, 3))
            0: return (int'(sb.ready_lo) + int'(sb.ready_hi)) / 2;
            1: return (int'(sb.present_lo) + int'(sb.present_hi)) / 2;
            2: return int'(sb.absent_lo) + int'($urandom_range(0, 300));
            default: return int'($urandom_range(0, MAX_MV));
        endcase
    endfunction

    // Runs of jittered samples around a target, with stray and rejected samples mixed in
    task automatic play_phase(input int count);
        int target;
        int run_left;
        int mv;
        target = 0;
        run_left = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                target = pick_target();
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            case ($urandom_range(0, 7))
                0: mv = $urandom_range(0, MAX_MV);
                1: mv = $urandom_range(0, sb.accept_thr);
                default: mv = target + int'($urandom_range(0, 80)) - 40;
            endcase
            send_sample(clip_mv(mv));
        end
    endtask

    task automatic directed_checks();
        // Reset settings: first reading is a change with level zero, threshold is strict
        send_sample('0);
        send_sample(SAMPLE_BITS_DEF'(ACCEPT_THR_RST));
        send_sample(SAMPLE_BITS_DEF'(ACCEPT_THR_RST + 1));
        send_sample(SAMPLE_BITS_DEF'(MAX_MV));
        // All bands open, no dwell: ready wins; zero is rejected
        apply_setup(open_bands(1'b1, 1'b1, 1'b1, 0));
        send_sample('0);
        send_sample(SAMPLE_BITS_DEF'(2000));
        // Ready empty: present wins over absent
        apply_setup(open_bands(1'b0, 1'b1, 1'b1, 0));
        send_sample(SAMPLE_BITS_DEF'(1));
        send_sample(SAMPLE_BITS_DEF'(MAX_MV));
        // Only absent left
        apply_setup(open_bands(1'b0, 1'b0, 1'b1, 0));
        send_sample(SAMPLE_BITS_DEF'(2500));
        send_sample(SAMPLE_BITS_DEF'(2500));
        // Level in no band: class held
        apply_setup(open_bands(1'b0, 1'b0, 1'b0, 0));
        send_sample(SAMPLE_BITS_DEF'(1800));
        send_sample(SAMPLE_BITS_DEF'(1800));
        // Ready open again but dwell must exceed two first
        apply_setup(open_bands(1'b1, 1'b1, 1'b1, 2));
        repeat (5) send_sample(SAMPLE_BITS_DEF'(1700));
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : reading_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = sink_gaps ? $urandom_range(0, 3) : 0;
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
                hold_offs++;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_reading(o_vehicle_state, o_filtered_mv, o_state_changed);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_band_setup setup;
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_checks();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                setup = '{accept_thr: CFG_BITS'(ACCEPT_THR_RST),
                          ready_lo: CFG_BITS'(READY_LOW_RST),
                          ready_hi: CFG_BITS'(READY_HIGH_RST),
                          present_lo: CFG_BITS'(PRESENT_LOW_RST),
                          present_hi: CFG_BITS'(PRESENT_HIGH_RST),
                          absent_lo: CFG_BITS'(ABSENT_LOW_RST),
                          min_dwell: CFG_BITS'(MIN_DWELL_RST)};
            end else if (p >= RANDOM_PHASES - 2) begin
                setup = extreme_setup();
            end else if (p % 3 == 0) begin
                setup = scrambled_setup();
            end else begin
                setup = graded_setup();
            end
            apply_setup(setup);
            // Vary which side idles; one phase runs flat out on both
            src_gaps  = !(p == 1 || p == 4 || p == 5);
            sink_gaps = !(p == 1 || p == 2);
            // Stall the result side for a long stretch while samples keep coming
            if (p == 5) hold_off_req = 1'b1;
            play_phase(PHASE_ITEMS);
        end

        wait_drained();

        $display("Covered %0d samples under %0d register setups, %0d readings checked",
                 sb.samples, setups_applied, sb.readings);
        $display("State changes %0d; absent/present/ready readings %0d/%0d/%0d; hold-offs %0d",
                 sb.changes, sb.class_hits[CLS_ABSENT], sb.class_hits[CLS_PRESENT],
                 sb.class_hits[CLS_READY], hold_offs);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Timeout with %0d readings outstanding", sb.pending());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plc_pkg.sv
rtl/plc_cell.sv
rtl/pilot_level_classifier_unit.sv
verif/pilot_level_classifier_unit_tb.sv
